@@ hdl/image_rotate_resample_core_assert.svh @@
// Assertion macros shared by the image rotate/resample RTL.
`ifndef IMAGE_ROTATE_RESAMPLE_CORE_ASSERT_SVH
`define IMAGE_ROTATE_RESAMPLE_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define IRR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define IRR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/irr_pkg.sv @@
// Package: types, widths and codes of the image rotate/resample core.
package irr_pkg;

  // Default store geometry and fixed-point formats
  localparam int unsigned DEF_MAX_WIDTH  = 256;
  localparam int unsigned DEF_MAX_HEIGHT = 256;
  localparam int unsigned PIXEL_BITS     = 8;
  localparam int unsigned TRIG_FRAC_BITS = 14;

  // Field widths
  localparam int unsigned COORD_W    = 8;
  localparam int unsigned VALUE_W    = 8;
  localparam int unsigned CENTER_W   = 8;
  localparam int unsigned TRIG_W     = 16;
  localparam int unsigned DIM_W      = 9;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  // Datapath widths
  localparam int unsigned FRAC_W  = 8;                       // sub-pixel fraction
  localparam int unsigned ONE_W   = FRAC_W + 1;              // weight 0..256
  localparam int unsigned WPROD_W = 2 * ONE_W - 1;           // weight product 0..65536
  localparam int unsigned PROD_W  = COORD_W + 1 + TRIG_W;    // offset times trig
  localparam int unsigned SUM_W   = PROD_W + 2;              // rotated coordinate
  localparam int unsigned XF_W    = SUM_W - TRIG_FRAC_BITS;  // integer part
  localparam int unsigned TERM_W  = PIXEL_BITS + WPROD_W;
  localparam int unsigned ACC_W   = TERM_W + 2;
  localparam int unsigned HALF_ROUND = 1 << (2 * FRAC_W - 1);

  localparam logic [ONE_W-1:0]  WEIGHT_ONE = ONE_W'(1 << FRAC_W);
  localparam logic [FRAC_W-1:0] NEAR_TIE   = FRAC_W'(1 << (FRAC_W - 1));
  localparam logic [VALUE_W-1:0] FILL_VALUE = VALUE_W'((1 << PIXEL_BITS) - 1);

  // Register reset values
  localparam logic signed [TRIG_W-1:0] COS_RESET = TRIG_W'(1 << TRIG_FRAC_BITS);
  localparam logic [DIM_W-1:0]         DIM_RESET = DIM_W'(256);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COS_VAL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_VAL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd6;

  // Operation and mode codes
  localparam logic OP_LOAD       = 1'b0;
  localparam logic OP_QUERY      = 1'b1;
  localparam logic MODE_NEAREST  = 1'b0;
  localparam logic MODE_BILINEAR = 1'b1;

  typedef struct packed {
    logic               op;
    logic [COORD_W-1:0] pix_x;
    logic [COORD_W-1:0] pix_y;
    logic [VALUE_W-1:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] out_value;
    logic               in_frame;
  } out_item_t;

endpackage

@@ hdl/image_rotate_resample_core.sv @@
// Top level of the image rotate/resample core: pixel store plus rotation datapath.
//
// Input channel (in_valid_i/in_ready_o/in_data_i): a load transaction writes one
// pixel into the store and gives no result; a query transaction names a
// destination pixel and gives exactly one result on the output channel
// (out_valid_o/out_ready_i/out_data_o). Results leave in query order.
// Throughput: one transaction per cycle while the output is not stalled, loads
// and queries mixed freely; the four-bank store reads all bilinear neighbors
// together and takes a load write on its separate write port.
// The store is four parity banks (row bit 0, column bit 0), each
// ceil(MAX_WIDTH/2) x ceil(MAX_HEIGHT/2). Writes and reads are issued from
// one stage in transaction order, so no forwarding is needed.
// Reset clears the pipeline valid bits and sets the registers to their
// defaults; the store is not cleared, so it needs no clearing pass.
// A stalled receiver holds the output; the pipeline closes its bubbles and
// in_ready_o drops only once every stage is full and stages 3 on hold queries.
// The user writes configuration (cfg_we_i/cfg_index_i/cfg_wdata_i) only while
// idle; the block itself does not enforce it.
`include "image_rotate_resample_core_assert.svh"

module image_rotate_resample_core #(
  parameter int unsigned MAX_WIDTH  = irr_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = irr_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  irr_pkg::in_item_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output irr_pkg::out_item_t               out_data_o,
  input  logic                             cfg_we_i,
  input  logic [irr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [irr_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  // Store geometry
  localparam int unsigned XC_W        = $clog2(MAX_WIDTH) + 1;  // column incl. +1
  localparam int unsigned YC_W        = $clog2(MAX_HEIGHT) + 1;
  localparam int unsigned CB_W        = XC_W - 1;               // bank column
  localparam int unsigned RB_W        = YC_W - 1;               // bank row
  localparam int unsigned BANK_COLS   = (MAX_WIDTH + 1) / 2;
  localparam int unsigned BANK_ROWS   = (MAX_HEIGHT + 1) / 2;
  localparam int unsigned BANK_DEPTH  = BANK_COLS * BANK_ROWS;
  localparam int unsigned BANK_AW     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int unsigned ADDR_CALC_W = CB_W + RB_W + 1;
  localparam int unsigned XF_W        = irr_pkg::XF_W;
  localparam int unsigned XH_W        = XF_W + 1;
  localparam int unsigned SUM_W       = irr_pkg::SUM_W;
  localparam int unsigned PROD_W      = irr_pkg::PROD_W;
  localparam int unsigned TFB         = irr_pkg::TRIG_FRAC_BITS;
  localparam int unsigned FRAC_W      = irr_pkg::FRAC_W;
  localparam int unsigned ONE_W       = irr_pkg::ONE_W;
  localparam int unsigned WPROD_W     = irr_pkg::WPROD_W;
  localparam int unsigned TERM_W      = irr_pkg::TERM_W;
  localparam int unsigned ACC_W       = irr_pkg::ACC_W;
  localparam int unsigned PIXEL_BITS  = irr_pkg::PIXEL_BITS;

  // Linear address inside one bank
  function automatic logic [BANK_AW-1:0] bank_addr(input logic [RB_W-1:0] rowh,
                                                   input logic [CB_W-1:0] colh);
    logic [ADDR_CALC_W-1:0] lin;
    lin = ADDR_CALC_W'(rowh) * ADDR_CALC_W'(BANK_COLS) + ADDR_CALC_W'(colh);
    return lin[BANK_AW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [irr_pkg::CENTER_W-1:0]      cx_q, cy_q;
  logic signed [irr_pkg::TRIG_W-1:0] cos_q, sin_q;
  logic                              mode_q;
  logic [irr_pkg::DIM_W-1:0]         width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      cos_q    <= irr_pkg::COS_RESET;
      sin_q    <= '0;
      mode_q   <= irr_pkg::MODE_BILINEAR;
      width_q  <= irr_pkg::DIM_RESET;
      height_q <= irr_pkg::DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        irr_pkg::REG_CENTER_X: cx_q     <= cfg_wdata_i[irr_pkg::CENTER_W-1:0];
        irr_pkg::REG_CENTER_Y: cy_q     <= cfg_wdata_i[irr_pkg::CENTER_W-1:0];
        irr_pkg::REG_COS_VAL:  cos_q    <= $signed(cfg_wdata_i[irr_pkg::TRIG_W-1:0]);
        irr_pkg::REG_SIN_VAL:  sin_q    <= $signed(cfg_wdata_i[irr_pkg::TRIG_W-1:0]);
        irr_pkg::REG_MODE:     mode_q   <= cfg_wdata_i[0];
        irr_pkg::REG_WIDTH:    width_q  <= cfg_wdata_i[irr_pkg::DIM_W-1:0];
        irr_pkg::REG_HEIGHT:   height_q <= cfg_wdata_i[irr_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. A stage loads when it is empty or its successor loads.
  // A load leaves stage 3 unconditionally (it ends with the store write).
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q, out_valid_q;
  logic ld1, ld2, ld3, ld4, ld5, ld_out;

  irr_pkg::in_item_t s1_item_q, s2_item_q, s3_item_q;

  assign ld_out     = !out_valid_q || out_ready_i;
  assign ld5        = !s5_valid_q || ld_out;
  assign ld4        = !s4_valid_q || ld5;
  assign ld3        = !s3_valid_q || (s3_item_q.op == irr_pkg::OP_LOAD) || ld4;
  assign ld2        = !s2_valid_q || ld3;
  assign ld1        = !s1_valid_q || ld2;
  assign in_ready_o = ld1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ld1)    s1_valid_q  <= in_valid_i;
      if (ld2)    s2_valid_q  <= s1_valid_q;
      if (ld3)    s3_valid_q  <= s2_valid_q;
      // only queries go past the store stage
      if (ld4)    s4_valid_q  <= s3_valid_q && (s3_item_q.op == irr_pkg::OP_QUERY);
      if (ld5)    s5_valid_q  <= s4_valid_q;
      if (ld_out) out_valid_q <= s5_valid_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 -> 2: offsets from the center and the four rotation products
  // ---------------------------------------------------------------------------
  logic signed [irr_pkg::COORD_W:0] dx, dy;
  logic signed [PROD_W-1:0] s2_dxc_q, s2_dys_q, s2_dxs_q, s2_dyc_q;

  assign dx = $signed({1'b0, s1_item_q.pix_x}) - $signed({1'b0, cx_q});
  assign dy = $signed({1'b0, cy_q}) - $signed({1'b0, s1_item_q.pix_y});

  always_ff @(posedge clk_i) begin
    if (ld1) s1_item_q <= in_data_i;
    if (ld2) begin
      s2_item_q <= s1_item_q;
      s2_dxc_q  <= PROD_W'(dx) * PROD_W'(cos_q);
      s2_dys_q  <= PROD_W'(dy) * PROD_W'(sin_q);
      s2_dxs_q  <= PROD_W'(dx) * PROD_W'(sin_q);
      s2_dyc_q  <= PROD_W'(dy) * PROD_W'(cos_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2 -> 3: source point in Q.TRIG_FRAC_BITS
  //   sx = cx + dx*c - dy*s,  sy = cy - (dx*s + dy*c)
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] cx_ext, cy_ext;
  logic signed [SUM_W-1:0] s3_sx_q, s3_sy_q;

  assign cx_ext = $signed(SUM_W'(cx_q)) <<< TFB;
  assign cy_ext = $signed(SUM_W'(cy_q)) <<< TFB;

  always_ff @(posedge clk_i) begin
    if (ld3) begin
      s3_item_q <= s2_item_q;
      s3_sx_q   <= cx_ext + SUM_W'(s2_dxc_q) - SUM_W'(s2_dys_q);
      s3_sy_q   <= cy_ext - (SUM_W'(s2_dxs_q) + SUM_W'(s2_dyc_q));
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: frame test, weights and bank addresses; store access issue.
  // Floor of the source point is the top of the word (arithmetic shift),
  // the fraction the 8 bits below it. Nearest mode runs through the same
  // mixer with one weight of 1.0 and three of zero.
  // ---------------------------------------------------------------------------
  logic signed [XF_W-1:0]   xf, yf;
  logic [FRAC_W-1:0]        qx, qy;
  logic                     near_x, near_y, inc_x, inc_y;
  logic signed [XH_W-1:0]   xhi, yhi;
  logic [irr_pkg::DIM_W-1:0] w_lim, h_lim;
  logic                     src_in_img;
  logic [ONE_W-1:0]         wx0, wx1, wy0, wy1;
  logic [3:0][WPROD_W-1:0]  w_d;
  logic [XC_W-1:0]          xu, xu1, wr_x;
  logic [YC_W-1:0]          yu, yu1, wr_y;
  logic                     wr_in_range;
  logic [BANK_AW-1:0]       wr_addr;

  assign xf = $signed(s3_sx_q[SUM_W-1:TFB]);
  assign yf = $signed(s3_sy_q[SUM_W-1:TFB]);
  assign qx = s3_sx_q[TFB-1 -: FRAC_W];
  assign qy = s3_sy_q[TFB-1 -: FRAC_W];

  // ties go to the floor corner
  assign near_x = qx > irr_pkg::NEAR_TIE;
  assign near_y = qy > irr_pkg::NEAR_TIE;
  assign inc_x  = (mode_q == irr_pkg::MODE_NEAREST) ? near_x : (qx != '0);
  assign inc_y  = (mode_q == irr_pkg::MODE_NEAREST) ? near_y : (qy != '0);

  assign xhi = $signed({xf[XF_W-1], xf}) + $signed({{XF_W{1'b0}}, inc_x});
  assign yhi = $signed({yf[XF_W-1], yf}) + $signed({{XF_W{1'b0}}, inc_y});

  // image in use, saturated to the store
  assign w_lim = (32'(width_q) > MAX_WIDTH) ? irr_pkg::DIM_W'(MAX_WIDTH) : width_q;
  assign h_lim = (32'(height_q) > MAX_HEIGHT) ? irr_pkg::DIM_W'(MAX_HEIGHT) : height_q;

  assign src_in_img = !xf[XF_W-1] && !yf[XF_W-1] &&
                      (xhi < $signed(XH_W'(w_lim))) && (yhi < $signed(XH_W'(h_lim)));

  always_comb begin
    if (mode_q == irr_pkg::MODE_NEAREST) begin
      wx1 = near_x ? irr_pkg::WEIGHT_ONE : '0;
      wy1 = near_y ? irr_pkg::WEIGHT_ONE : '0;
    end else begin
      wx1 = ONE_W'(qx);
      wy1 = ONE_W'(qy);
    end
    wx0    = irr_pkg::WEIGHT_ONE - wx1;
    wy0    = irr_pkg::WEIGHT_ONE - wy1;
    // index {ry, rx}: relative corner
    w_d[0] = WPROD_W'(wx0) * WPROD_W'(wy0);
    w_d[1] = WPROD_W'(wx1) * WPROD_W'(wy0);
    w_d[2] = WPROD_W'(wx0) * WPROD_W'(wy1);
    w_d[3] = WPROD_W'(wx1) * WPROD_W'(wy1);
  end

  // floor corner and its +1 neighbors; only meaningful when inside
  assign xu  = xf[XC_W-1:0];
  assign yu  = yf[YC_W-1:0];
  assign xu1 = xu + 1'b1;
  assign yu1 = yu + 1'b1;

  // load write address
  assign wr_x        = XC_W'(s3_item_q.pix_x);
  assign wr_y        = YC_W'(s3_item_q.pix_y);
  assign wr_in_range = (32'(s3_item_q.pix_x) < MAX_WIDTH) &&
                       (32'(s3_item_q.pix_y) < MAX_HEIGHT);
  assign wr_addr     = bank_addr(wr_y[YC_W-1:1], wr_x[XC_W-1:1]);

  logic [3:0][PIXEL_BITS-1:0] bank_rd;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic BX = 1'(b % 2);
    localparam logic BY = 1'(b / 2);
    logic [XC_W-1:0]    rd_col;
    logic [YC_W-1:0]    rd_row;
    logic [BANK_AW-1:0] rd_addr;
    logic               wr_en;

    // each bank holds exactly one of the two candidate columns and rows
    assign rd_col  = (xu[0] == BX) ? xu : xu1;
    assign rd_row  = (yu[0] == BY) ? yu : yu1;
    assign rd_addr = bank_addr(rd_row[YC_W-1:1], rd_col[XC_W-1:1]);
    assign wr_en   = s3_valid_q && (s3_item_q.op == irr_pkg::OP_LOAD) && wr_in_range &&
                     (s3_item_q.pix_x[0] == BX) && (s3_item_q.pix_y[0] == BY);

    irr_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk_i     (clk_i),
      .wr_en_i   (wr_en),
      .wr_addr_i (wr_addr),
      .wr_data_i (s3_item_q.load_value[PIXEL_BITS-1:0]),
      .rd_en_i   (ld4),
      .rd_addr_i (rd_addr),
      .rd_data_o (bank_rd[b])
    );
  end

  // ---------------------------------------------------------------------------
  // Stage 4: store data arrives; route banks to corners and weight them
  // ---------------------------------------------------------------------------
  logic                    s4_inside_q, s4_px_q, s4_py_q;
  logic [3:0][WPROD_W-1:0] s4_w_q;
  logic [3:0][TERM_W-1:0]  term_d;

  always_ff @(posedge clk_i) begin
    if (ld4) begin
      s4_inside_q <= src_in_img;
      s4_px_q     <= xu[0];
      s4_py_q     <= yu[0];
      s4_w_q      <= w_d;
    end
  end

  always_comb begin
    logic [1:0]         bsel;
    logic [1:0]         ridx;
    logic [WPROD_W-1:0] wsel;
    for (int b = 0; b < 4; b++) begin
      bsel = 2'(b);
      ridx = bsel ^ {s4_py_q, s4_px_q};
      wsel = s4_w_q[ridx];
      // a zero-weight corner may sit outside the written image
      term_d[b] = (wsel == '0) ? '0 : TERM_W'(bank_rd[b]) * TERM_W'(wsel);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5 -> output: sum, round half up, or fill when outside
  // ---------------------------------------------------------------------------
  logic                   s5_inside_q;
  logic [3:0][TERM_W-1:0] s5_term_q;
  logic [ACC_W-1:0]       acc;
  irr_pkg::out_item_t     out_d, out_data_q;

  always_ff @(posedge clk_i) begin
    if (ld5) begin
      s5_inside_q <= s4_inside_q;
      s5_term_q   <= term_d;
    end
  end

  assign acc = ACC_W'(s5_term_q[0]) + ACC_W'(s5_term_q[1]) + ACC_W'(s5_term_q[2]) +
               ACC_W'(s5_term_q[3]) + ACC_W'(irr_pkg::HALF_ROUND);

  assign out_d.out_value = s5_inside_q ?
                           irr_pkg::VALUE_W'(acc[2*FRAC_W +: PIXEL_BITS]) :
                           irr_pkg::FILL_VALUE;
  assign out_d.in_frame  = s5_inside_q;

  always_ff @(posedge clk_i) begin
    if (ld_out) out_data_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `IRR_ASSERT_NEXT(a_bank_hold, s4_valid_q && !ld4, $stable(bank_rd), "store data moved under a stalled query")
  `IRR_ASSERT_NOW(a_fill_value, out_valid_o && !out_data_o.in_frame, out_data_o.out_value == irr_pkg::FILL_VALUE, "out-of-frame result without fill value")
  `IRR_ASSERT_NOW(a_ready_stall, !in_ready_o, out_valid_o && !out_ready_i, "input blocked without output stall")

endmodule

@@ hdl/irr_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
module irr_ram #(
  parameter int unsigned WIDTH = irr_pkg::PIXEL_BITS,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ tb/image_rotate_resample_checker.sv @@
// Checker for the image rotate/resample core: pixel store mirror, prediction, compare.
`timescale 1ns / 1ps

module image_rotate_resample_checker
  import irr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_item_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_item_t             out_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam int STORE_W  = 256;
  localparam int Q8_SHIFT = TRIG_FRAC_BITS - FRAC_W;

  logic [VALUE_W-1:0]       image_mem [0:STORE_W*STORE_W-1];
  logic [CENTER_W-1:0]      center_x_q, center_y_q;
  logic signed [TRIG_W-1:0] cos_q, sin_q;
  logic                     mode_q;
  logic [DIM_W-1:0]         width_q, height_q;

  out_item_t pending_pixels [$];
  out_item_t oldest;
  int        mismatches;

  assign fail_count_o = mismatches;

  // Source point of a destination pixel, then nearest or bilinear sample.
  function automatic out_item_t rotate_sample(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
    longint    dx, dy, sx_full, sy_full, sx8, sy8, xf, yf, xc, yc, nx, ny, w, h;
    longint    unsigned wx0, wx1, wy0, wy1, acc;
    int        qx, qy;
    out_item_t res;
    w = (width_q > STORE_W) ? STORE_W : longint'(width_q);
    h = (height_q > STORE_W) ? STORE_W : longint'(height_q);
    dx = longint'(px) - longint'(center_x_q);
    dy = longint'(center_y_q) - longint'(py);
    sx_full = (longint'(center_x_q) <<< TRIG_FRAC_BITS) + dx * longint'(cos_q)
              - dy * longint'(sin_q);
    sy_full = (longint'(center_y_q) <<< TRIG_FRAC_BITS)
              - (dx * longint'(sin_q) + dy * longint'(cos_q));
    sx8 = sx_full >>> Q8_SHIFT;
    sy8 = sy_full >>> Q8_SHIFT;
    xf = sx8 >>> FRAC_W;
    yf = sy8 >>> FRAC_W;
    qx = int'(sx8 & 255);
    qy = int'(sy8 & 255);
    res.out_value = FILL_VALUE;
    res.in_frame  = 1'b0;
    if (mode_q == MODE_NEAREST) begin
      // exact half goes to the floor corner
      nx = xf + ((qx > 128) ? 1 : 0);
      ny = yf + ((qy > 128) ? 1 : 0);
      if (sx8 >= 0 && sy8 >= 0 && nx < w && ny < h) begin
        res.out_value = image_mem[int'(ny) * STORE_W + int'(nx)];
        res.in_frame  = 1'b1;
      end
    end else begin
      xc = xf + ((qx != 0) ? 1 : 0);
      yc = yf + ((qy != 0) ? 1 : 0);
      if (xf >= 0 && yf >= 0 && xc < w && yc < h) begin
        wx1 = qx; wx0 = 256 - qx;
        wy1 = qy; wy0 = 256 - qy;
        acc = wx0 * wy0 * image_mem[int'(yf) * STORE_W + int'(xf)]
            + wx1 * wy0 * image_mem[int'(yf) * STORE_W + int'(xc)]
            + wx0 * wy1 * image_mem[int'(yc) * STORE_W + int'(xf)]
            + wx1 * wy1 * image_mem[int'(yc) * STORE_W + int'(xc)]
            + HALF_ROUND;
        res.out_value = VALUE_W'(acc >> 16);
        res.in_frame  = 1'b1;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      cos_q      <= COS_RESET;
      sin_q      <= '0;
      mode_q     <= MODE_BILINEAR;
      width_q    <= DIM_RESET;
      height_q   <= DIM_RESET;
      pending_pixels.delete();
      mismatches = 0;
      pending_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_CENTER_X: center_x_q <= cfg_wdata_i[CENTER_W-1:0];
          REG_CENTER_Y: center_y_q <= cfg_wdata_i[CENTER_W-1:0];
          REG_COS_VAL:  cos_q      <= cfg_wdata_i;
          REG_SIN_VAL:  sin_q      <= cfg_wdata_i;
          REG_MODE:     mode_q     <= cfg_wdata_i[0];
          REG_WIDTH:    width_q    <= cfg_wdata_i[DIM_W-1:0];
          REG_HEIGHT:   height_q   <= cfg_wdata_i[DIM_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.op == OP_LOAD)
          image_mem[{in_data_i.pix_y, in_data_i.pix_x}] <= in_data_i.load_value;
        else
          pending_pixels = {pending_pixels,
                            rotate_sample(in_data_i.pix_x, in_data_i.pix_y)};
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_pixels.size() == 0) begin
          $error("result with no query waiting: out_value %0d in_frame %0d",
                 out_data_i.out_value, out_data_i.in_frame);
          mismatches++;
        end else begin
          oldest = pending_pixels.pop_front();
          if (out_data_i.out_value !== oldest.out_value) begin
            $error("out_value: expected %0d, actual %0d", oldest.out_value,
                   out_data_i.out_value);
            mismatches++;
          end
          if (out_data_i.in_frame !== oldest.in_frame) begin
            $error("in_frame: expected %0d, actual %0d", oldest.in_frame,
                   out_data_i.in_frame);
            mismatches++;
          end
        end
      end
      pending_o <= pending_pixels.size();
    end
  end

endmodule

@@ tb/image_rotate_resample_core_test.sv @@
// Top of the image rotate/resample testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module image_rotate_resample_core_test;
  import irr_pkg::*;

  localparam int ITEM_TARGET = 1150;
  localparam int CYCLE_LIMIT = 400000;
  // loads leave no trace on the output side, so give the pipe some extra room
  // before touching registers
  localparam int SETTLE_CYCLES = 10;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  in_item_t              in_data   = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;
  int        fail_count;
  int        pending_results;

  int items_sent = 0;
  int cycles     = 0;
  int phase_no;

  // Pixels written so far; queries only ever read inside the written area.
  bit loaded_map [0:65535];

  image_rotate_resample_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  image_rotate_resample_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .fail_count_o(fail_count),
    .pending_o   (pending_results)
  );

  always #6 clk = ~clk;

  // Idling schedule over the run, by thirds of the transaction count:
  // slow receiver first, then slow sender, then both at full rate.
  function automatic int sender_gap_pct();
    if (items_sent < ITEM_TARGET / 3) return 26;
    if (items_sent < 2 * ITEM_TARGET / 3) return 78;
    return 0;
  endfunction

  function automatic int receiver_gap_pct();
    if (items_sent < ITEM_TARGET / 3) return 78;
    if (items_sent < 2 * ITEM_TARGET / 3) return 26;
    return 0;
  endfunction

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= receiver_gap_pct());
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // One input transaction. Entered at a rising edge; returns at the edge that
  // accepted it, leaving valid high so a back-to-back transaction follows with
  // no idle gap unless the gap roll says otherwise.
  task automatic send_item(in_item_t item);
    while ($urandom_range(0, 99) < sender_gap_pct()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_load(int x, int y, int value);
    in_item_t item;
    item.op         = OP_LOAD;
    item.pix_x      = COORD_W'(x);
    item.pix_y      = COORD_W'(y);
    item.load_value = VALUE_W'(value);
    loaded_map[y * 256 + x] = 1'b1;
    send_item(item);
  endtask

  // load_value is random on queries too: the block must not care about it
  task automatic send_query(int x, int y);
    in_item_t item;
    item.op         = OP_QUERY;
    item.pix_x      = COORD_W'(x);
    item.pix_y      = COORD_W'(y);
    item.load_value = VALUE_W'($urandom_range(0, 255));
    send_item(item);
  endtask

  // Drop valid, wait for every expected pixel, then let the pipe empty of loads.
  // The pending count is registered behind the handshake, so step the clock first.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all seven registers back to back; only called while idle.
  task automatic set_config(int cx, int cy, int cos_v, int sin_v, logic mode,
                            int w, int h);
    logic [CFG_IDX_W-1:0]  idx   [7];
    logic [CFG_DATA_W-1:0] value [7];
    idx[0] = REG_CENTER_X; value[0] = CFG_DATA_W'(cx);
    idx[1] = REG_CENTER_Y; value[1] = CFG_DATA_W'(cy);
    idx[2] = REG_COS_VAL;  value[2] = CFG_DATA_W'(cos_v);
    idx[3] = REG_SIN_VAL;  value[3] = CFG_DATA_W'(sin_v);
    idx[4] = REG_MODE;     value[4] = CFG_DATA_W'(mode);
    idx[5] = REG_WIDTH;    value[5] = CFG_DATA_W'(w);
    idx[6] = REG_HEIGHT;   value[6] = CFG_DATA_W'(h);
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= value[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Query coordinates mostly land just around the image in use so that
  // rotated points fall on both sides of the frame edges.
  function automatic int pick_coord(int extent);
    if ($urandom_range(0, 99) < 75)
      return $urandom_range(0, (extent + 2 > 255) ? 255 : extent + 2);
    return $urandom_range(0, 255);
  endfunction

  task automatic random_phase(int phase_idx);
    int   w, h, ww, hh, cx, cy, cos_v, sin_v;
    logic mode;
    // every other phase takes one of the edge geometries: full-size rows and
    // columns, oversize widths and heights that saturate, and empty images
    if (phase_idx % 2 == 1) begin
      case ((phase_idx / 2) % 6)
        0: begin w = 256; h = 1;   end
        1: begin w = 511; h = 1;   end
        2: begin w = 1;   h = 256; end
        3: begin w = 1;   h = 511; end
        4: begin w = 0;   h = 7;   end
        default: begin w = 9; h = 0; end
      endcase
    end else begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 12);
    end
    ww = (w > 256) ? 256 : w;
    hh = (h > 256) ? 256 : h;
    cx = (ww > 0 && $urandom_range(0, 99) < 80) ? $urandom_range(0, ww - 1)
                                                : $urandom_range(0, 255);
    cy = (hh > 0 && $urandom_range(0, 99) < 80) ? $urandom_range(0, hh - 1)
                                                : $urandom_range(0, 255);
    if ($urandom_range(0, 1)) begin
      // exact quarter turns, eighth turns and a thirty-degree step
      case ($urandom_range(0, 7))
        0: begin cos_v = 16384;  sin_v = 0;      end
        1: begin cos_v = 0;      sin_v = 16384;  end
        2: begin cos_v = -16384; sin_v = 0;      end
        3: begin cos_v = 0;      sin_v = -16384; end
        4: begin cos_v = 11585;  sin_v = 11585;  end
        5: begin cos_v = 11585;  sin_v = -11585; end
        6: begin cos_v = -11585; sin_v = -11585; end
        default: begin cos_v = 14189; sin_v = 8192; end
      endcase
    end else begin
      // arbitrary pairs scale as well as rotate
      cos_v = int'($urandom_range(0, 32768)) - 16384;
      sin_v = int'($urandom_range(0, 32768)) - 16384;
    end
    mode = $urandom_range(0, 1);
    set_config(cx, cy, cos_v, sin_v, mode, w, h);

    // fill whatever part of the image in use has never been written
    for (int y = 0; y < hh; y++)
      for (int x = 0; x < ww; x++)
        if (!loaded_map[y * 256 + x]) send_load(x, y, $urandom_range(0, 255));
    if (ww > 0 && hh > 0)
      repeat ($urandom_range(0, 6))
        send_load($urandom_range(0, ww - 1), $urandom_range(0, hh - 1),
                  $urandom_range(0, 255));

    // queries with loads mixed in, so writes land right between reads
    repeat ($urandom_range(20, 60)) begin
      if ($urandom_range(0, 99) < 12) begin
        if (ww > 0 && hh > 0 && $urandom_range(0, 1))
          send_load($urandom_range(0, ww - 1), $urandom_range(0, hh - 1),
                    $urandom_range(0, 255));
        else
          send_load($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      end else begin
        send_query(pick_coord(ww), pick_coord(hh));
      end
    end
    settle();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 2x2 image, identity about (1,1): corners, value extremes, far queries
    set_config(1, 1, 16384, 0, MODE_NEAREST, 2, 2);
    send_load(0, 0, 8'h00);
    send_load(1, 0, 8'hFF);
    send_load(0, 1, 8'h55);
    send_load(1, 1, 8'hAA);
    send_query(0, 0);
    send_query(1, 1);
    send_query(255, 255);
    send_query(0, 255);
    settle();

    // half scale about the origin: most sources sit exactly on half pixels,
    // so nearest hits its tie rule and bilinear its rounding midpoint
    set_config(0, 0, 8192, 0, MODE_NEAREST, 2, 2);
    send_query(1, 1);
    send_query(3, 3);
    send_query(2, 1);
    settle();
    set_config(0, 0, 8192, 0, MODE_BILINEAR, 2, 2);
    send_query(1, 1);
    send_query(2, 2);
    send_query(3, 3);
    settle();

    // half turn: one point stays, its neighbor maps to a source past the far corner
    set_config(1, 1, -16384, 0, MODE_BILINEAR, 2, 2);
    send_query(1, 1);
    send_query(0, 0);
    settle();

    // quarter turn, nearest
    set_config(1, 1, 0, 16384, MODE_NEAREST, 2, 2);
    send_query(0, 1);
    send_query(1, 0);
    settle();

    // zero width, then zero height: everything is fill
    set_config(0, 0, 16384, 0, MODE_BILINEAR, 0, 2);
    send_query(0, 0);
    settle();
    set_config(0, 0, 16384, 0, MODE_NEAREST, 2, 0);
    send_query(0, 0);
    settle();

    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      random_phase(phase_no);
      phase_no++;
    end

    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/irr_pkg.sv
hdl/irr_ram.sv
hdl/image_rotate_resample_core.sv
tb/image_rotate_resample_checker.sv
tb/image_rotate_resample_core_test.sv
